// ===== hw/rtl/dtpc_pkg.sv =====
// ============================================================================
// dtpc_pkg
// Shared constants and codes for the depth-to-point-cloud converter.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package dtpc_pkg;

  // Frame geometry
  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int DEPTH_BITS   = 11;
  localparam int PIX_COUNT    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(PIX_COUNT);

  // Fixed field widths
  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int SAMP_W  = 11;
  localparam int MAP_W   = COL_W + ROW_W;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 24;

  localparam logic [SAMP_W-1:0] DEPTH_MASK = SAMP_W'((1 << DEPTH_BITS) - 1);

  // Item actions
  localparam logic [1:0] ACT_DEPTH  = 2'd0;
  localparam logic [1:0] ACT_REMAP  = 2'd1;
  localparam logic [1:0] ACT_PIXEL  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_INV_FX = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_INV_FY = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_CX     = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_CY     = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_BASE   = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_OFFSET = 3'd5;

  // Register reset values
  localparam logic [23:0] RST_INV_FX = 24'd28103;
  localparam logic [23:0] RST_INV_FY = 24'd28103;
  localparam logic [13:0] RST_CX     = 14'd5024;
  localparam logic [12:0] RST_CY     = 13'd3856;
  localparam logic [19:0] RST_BASE   = 20'd89129;
  localparam logic [20:0] RST_OFFSET = 21'd1153;

  // Arithmetic
  localparam int          Z_SCALE   = 4320;
  localparam int          DIV_N_W   = 51;
  localparam int          DIV_D_W   = 33;
  localparam int          DIV_CNT_W = $clog2(DIV_N_W);
  localparam logic [31:0] S32_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN   = 32'h8000_0000;

endpackage

`default_nettype wire

// ===== hw/rtl/dtpc_ram.sv =====
// ============================================================================
// dtpc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dtpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/depth_to_point_cloud.sv =====
// ============================================================================
// depth_to_point_cloud
// Depth frame store, remap table and pinhole back-projection to Q16.16.
// ============================================================================
// Use: words arrive on the in_ channel (valid/stall). A depth or remap write
// is taken while the block is idle and the block is ready again on the next
// cycle. A pixel request reads the raw depth at the pixel and the depth at its
// remapped position, then works out z with a restoring divider (one quotient
// bit per cycle) and x and y on one shared 32x16 multiplier. A pixel request
// occupies the block from acceptance until its result word is loaded into the
// output register. The next word is accepted while a finished result still
// waits on the out_ channel; if the receiver stalls, the result is held
// unchanged and a later pixel request waits in its last step until the output
// register is free. Configuration registers are written through cfg_ (always
// ready); the user must write them only while the block is idle, which the
// block itself does not enforce. After reset the remap table is set to
// identity by a clearing pass (one entry a cycle), during which in_stall stays
// high. The depth frame is not cleared.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module depth_to_point_cloud (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_action,
  input  wire logic [9:0]                      in_pixel_x,
  input  wire logic [8:0]                      in_pixel_y,
  input  wire logic [10:0]                     in_depth_value,
  input  wire logic [9:0]                      in_map_x,
  input  wire logic [8:0]                      in_map_y,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [10:0]                          out_raw_depth,
  output logic signed [31:0]                   out_cloud_x,
  output logic signed [31:0]                   out_cloud_y,
  output logic signed [31:0]                   out_cloud_z,
  output logic                                 out_saturated,
  // Configuration
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dtpc_pkg::CIDX_W-1:0]     cfg_index,
  input  wire logic [dtpc_pkg::CDATA_W-1:0]    cfg_data
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD_A, S_RD_B, S_RD_C, S_UY, S_NUM, S_DIV,
    S_ZF, S_X0, S_X1, S_XF, S_Y0, S_Y1, S_YF, S_DONE
  } state_t;

  localparam int AW = dtpc_pkg::ADDR_W;
  localparam int CW = dtpc_pkg::COL_W;
  localparam int RW = dtpc_pkg::ROW_W;
  localparam int SW = dtpc_pkg::SAMP_W;
  localparam int NW = dtpc_pkg::DIV_N_W;
  localparam int DW = dtpc_pkg::DIV_D_W;
  localparam int KW = dtpc_pkg::DIV_CNT_W;

  localparam logic [CW-1:0] LAST_COL = CW'(dtpc_pkg::FRAME_WIDTH - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(dtpc_pkg::FRAME_HEIGHT - 1);
  localparam logic [AW-1:0] LAST_PIX = AW'(dtpc_pkg::PIX_COUNT - 1);

  function automatic logic [AW-1:0] pix_addr(input logic [RW-1:0] row,
                                             input logic [CW-1:0] col);
    pix_addr = AW'(row) * AW'(dtpc_pkg::FRAME_WIDTH) + AW'(col);
  endfunction

  // Round a 64-bit product magnitude by 20 bits, apply the sign and
  // saturate to 32 bits. Bit 32 of the result is the clamp flag.
  function automatic logic [32:0] sat_round(input logic [63:0] acc,
                                            input logic        neg);
    logic [63:0] r;
    logic [43:0] m;
    r = acc + 64'(1 << 19);
    m = r[63:20];
    if (!neg) begin
      if (m > 44'(dtpc_pkg::S32_MAX)) sat_round = {1'b1, dtpc_pkg::S32_MAX};
      else                            sat_round = {1'b0, m[31:0]};
    end else begin
      if (m > 44'(dtpc_pkg::S32_MIN)) sat_round = {1'b1, dtpc_pkg::S32_MIN};
      else                            sat_round = {1'b0, ~m[31:0] + 32'd1};
    end
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic [CW-1:0]   clr_col_r, clr_col_nxt;
  logic [RW-1:0]   clr_row_r, clr_row_nxt;

  logic [23:0]     ifx_r, ifx_nxt;
  logic [23:0]     ify_r, ify_nxt;
  logic [13:0]     cx_r, cx_nxt;
  logic [12:0]     cy_r, cy_nxt;
  logic [19:0]     base_r, base_nxt;
  logic [20:0]     off_r, off_nxt;

  logic [CW-1:0]   px_r, px_nxt;
  logic [RW-1:0]   py_r, py_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [SW-1:0]   raw_r, raw_nxt;
  logic            den_neg_r, den_neg_nxt;
  logic            den_zero_r, den_zero_nxt;
  logic [31:0]     mag_r, mag_nxt;
  logic [30:0]     ux_r, ux_nxt;
  logic [30:0]     uy_r, uy_nxt;
  logic [NW-1:0]   div_n_r, div_n_nxt;
  logic [DW-1:0]   div_d_r, div_d_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [NW-1:0]   quo_r, quo_nxt;
  logic [KW-1:0]   cnt_r, cnt_nxt;
  logic [31:0]     zmag_r, zmag_nxt;
  logic            z_neg_r, z_neg_nxt;
  logic [63:0]     acc_r, acc_nxt;
  logic [31:0]     rx_r, rx_nxt;
  logic [31:0]     ry_r, ry_nxt;
  logic [31:0]     rz_r, rz_nxt;
  logic            flag_r, flag_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [SW-1:0]   out_raw_r, out_raw_nxt;
  logic [31:0]     out_x_r, out_x_nxt;
  logic [31:0]     out_y_r, out_y_nxt;
  logic [31:0]     out_z_r, out_z_nxt;
  logic            out_sat_r, out_sat_nxt;

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  localparam int MAP_WD = dtpc_pkg::MAP_W;

  logic            dep_we;
  logic [AW-1:0]   dep_raddr;
  logic [SW-1:0]   dep_rdata;
  logic            map_we;
  logic [AW-1:0]   map_waddr;
  logic [MAP_WD-1:0] map_wdata;
  logic [MAP_WD-1:0] map_rdata;

  // Input decode
  logic            in_acc;
  logic [CW-1:0]   in_px, in_mx;
  logic [RW-1:0]   in_py, in_my;
  logic [AW-1:0]   in_idx;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_px    = (in_pixel_x > LAST_COL) ? LAST_COL : in_pixel_x;
  assign in_py    = (in_pixel_y > LAST_ROW) ? LAST_ROW : in_pixel_y;
  assign in_mx    = (in_map_x > LAST_COL) ? LAST_COL : in_map_x;
  assign in_my    = (in_map_y > LAST_ROW) ? LAST_ROW : in_map_y;
  assign in_idx   = pix_addr(in_py, in_px);

  assign dep_we    = in_acc && (in_action == dtpc_pkg::ACT_DEPTH);
  assign dep_raddr = (state_r == S_RD_B) ? pix_addr(map_rdata[MAP_WD-1:CW], map_rdata[CW-1:0])
                                         : idx_r;

  assign map_we    = (state_r == S_CLR) || (in_acc && (in_action == dtpc_pkg::ACT_REMAP));
  assign map_waddr = (state_r == S_CLR) ? clr_addr_r : in_idx;
  assign map_wdata = (state_r == S_CLR) ? {clr_row_r, clr_col_r} : {in_my, in_mx};

  dtpc_ram #(.WIDTH(SW), .DEPTH(dtpc_pkg::PIX_COUNT)) u_depth_ram (
    .clk   (clk),
    .we    (dep_we),
    .waddr (in_idx),
    .wdata (in_depth_value & dtpc_pkg::DEPTH_MASK),
    .raddr (dep_raddr),
    .rdata (dep_rdata)
  );

  dtpc_ram #(.WIDTH(MAP_WD), .DEPTH(dtpc_pkg::PIX_COUNT)) u_remap_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (idx_r),
    .rdata (map_rdata)
  );

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic signed [14:0] ax;
  logic signed [13:0] ay;
  logic [14:0]        ax_abs;
  logic [13:0]        ay_abs;
  logic signed [32:0] den;
  logic [32:0]        den_abs;
  logic [31:0]        mul_a;
  logic [15:0]        mul_b;
  logic [47:0]        prod;
  logic [DW:0]        trial;
  logic               q_big;
  logic [31:0]        q_c;
  logic               q_top;
  logic [32:0]        sr;

  assign ax     = $signed({1'b0, px_r, 4'b0000}) - $signed({1'b0, cx_r});
  assign ay     = $signed({1'b0, py_r, 4'b0000}) - $signed({1'b0, cy_r});
  assign ax_abs = ax[14] ? 15'(-ax) : 15'(ax);
  assign ay_abs = ay[13] ? 14'(-ay) : 14'(ay);

  assign den     = 33'($signed(off_r)) - $signed({2'b00, dep_rdata, 20'd0});
  assign den_abs = den[32] ? 33'(-den) : 33'(den);

  // The shared multiplier
  always_comb begin
    mul_a = zmag_r;
    mul_b = 16'd0;
    case (state_r)
      S_RD_C:  begin mul_a = {8'd0, ifx_r};  mul_b = {2'b00, ax_abs[13:0]}; end
      S_UY:    begin mul_a = {8'd0, ify_r};  mul_b = {3'b000, ay_abs[12:0]}; end
      S_NUM:   begin mul_a = {12'd0, base_r}; mul_b = 16'(dtpc_pkg::Z_SCALE); end
      S_X0:    mul_b = ux_r[15:0];
      S_X1:    mul_b = {1'b0, ux_r[30:16]};
      S_Y0:    mul_b = uy_r[15:0];
      S_Y1:    mul_b = {1'b0, uy_r[30:16]};
      default: mul_b = 16'd0;
    endcase
  end
  assign prod = 48'(mul_a) * 48'(mul_b);

  assign trial = {rem_r, div_n_r[NW-1]};
  assign q_big = quo_r > NW'(64'd1 << 31);
  assign q_c   = q_big ? dtpc_pkg::S32_MIN : quo_r[31:0];
  assign q_top = (q_c == dtpc_pkg::S32_MIN);
  assign sr    = sat_round(acc_r, (state_r == S_XF) ? (ax[14] ^ z_neg_r)
                                                    : !(ay[13] ^ z_neg_r));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    clr_col_nxt  = clr_col_r;
    clr_row_nxt  = clr_row_r;
    ifx_nxt = ifx_r; ify_nxt = ify_r; cx_nxt = cx_r; cy_nxt = cy_r;
    base_nxt = base_r; off_nxt = off_r;
    px_nxt = px_r; py_nxt = py_r; idx_nxt = idx_r; raw_nxt = raw_r;
    den_neg_nxt = den_neg_r; den_zero_nxt = den_zero_r; mag_nxt = mag_r;
    ux_nxt = ux_r; uy_nxt = uy_r;
    div_n_nxt = div_n_r; div_d_nxt = div_d_r; rem_nxt = rem_r;
    quo_nxt = quo_r; cnt_nxt = cnt_r;
    zmag_nxt = zmag_r; z_neg_nxt = z_neg_r; acc_nxt = acc_r;
    rx_nxt = rx_r; ry_nxt = ry_r; rz_nxt = rz_r; flag_nxt = flag_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_raw_nxt = out_raw_r; out_x_nxt = out_x_r; out_y_nxt = out_y_r;
    out_z_nxt = out_z_r; out_sat_nxt = out_sat_r;

    if (cfg_valid) begin
      case (cfg_index)
        dtpc_pkg::CFG_INV_FX: ifx_nxt  = cfg_data;
        dtpc_pkg::CFG_INV_FY: ify_nxt  = cfg_data;
        dtpc_pkg::CFG_CX:     cx_nxt   = cfg_data[13:0];
        dtpc_pkg::CFG_CY:     cy_nxt   = cfg_data[12:0];
        dtpc_pkg::CFG_BASE:   base_nxt = cfg_data[19:0];
        dtpc_pkg::CFG_OFFSET: off_nxt  = cfg_data[20:0];
        default: ;
      endcase
    end

    case (state_r)
      S_CLR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_col_r == LAST_COL) begin
          clr_col_nxt = '0;
          clr_row_nxt = clr_row_r + RW'(1);
        end else begin
          clr_col_nxt = clr_col_r + CW'(1);
        end
        if (clr_addr_r == LAST_PIX) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc && (in_action == dtpc_pkg::ACT_PIXEL)) begin
          px_nxt    = in_px;
          py_nxt    = in_py;
          idx_nxt   = in_idx;
          state_nxt = S_RD_A;
        end
      end
      S_RD_A: state_nxt = S_RD_B;
      S_RD_B: begin
        raw_nxt   = dep_rdata;
        state_nxt = S_RD_C;
      end
      S_RD_C: begin
        // Remapped depth is on the read port now.
        den_neg_nxt  = den[32];
        den_zero_nxt = (den == 33'sd0);
        mag_nxt      = den_abs[31:0];
        ux_nxt       = 31'((prod + 48'd128) >> 8);
        flag_nxt     = 1'b0;
        state_nxt    = S_UY;
      end
      S_UY: begin
        uy_nxt    = 31'((prod + 48'd128) >> 8);
        state_nxt = S_NUM;
      end
      S_NUM: begin
        // Dividend is 2*num + |den| and divisor 2*|den|, for round half up.
        div_n_nxt = NW'({prod[32:0], 17'd0}) + NW'(mag_r);
        div_d_nxt = {mag_r, 1'b0};
        rem_nxt   = '0;
        quo_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (trial >= {1'b0, div_d_r}) begin
          rem_nxt = DW'(trial - {1'b0, div_d_r});
          quo_nxt = {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DW-1:0];
          quo_nxt = {quo_r[NW-2:0], 1'b0};
        end
        div_n_nxt = {div_n_r[NW-2:0], 1'b0};
        cnt_nxt   = cnt_r + KW'(1);
        if (cnt_r == KW'(NW - 1)) state_nxt = S_ZF;
      end
      S_ZF: begin
        if (den_zero_r) begin
          zmag_nxt  = dtpc_pkg::S32_MAX;
          z_neg_nxt = 1'b0;
          rz_nxt    = ~dtpc_pkg::S32_MAX + 32'd1;
          flag_nxt  = 1'b1;
        end else if (den_neg_r) begin
          zmag_nxt  = q_c;
          z_neg_nxt = 1'b1;
          rz_nxt    = q_top ? dtpc_pkg::S32_MAX : q_c;
          flag_nxt  = q_big || q_top;
        end else begin
          zmag_nxt  = q_top ? dtpc_pkg::S32_MAX : q_c;
          z_neg_nxt = 1'b0;
          rz_nxt    = q_top ? (~dtpc_pkg::S32_MAX + 32'd1) : (~q_c + 32'd1);
          flag_nxt  = q_big || q_top;
        end
        state_nxt = S_X0;
      end
      S_X0: begin
        acc_nxt   = 64'(prod);
        state_nxt = S_X1;
      end
      S_X1: begin
        acc_nxt   = acc_r + (64'(prod) << 16);
        state_nxt = S_XF;
      end
      S_XF: begin
        rx_nxt    = sr[31:0];
        flag_nxt  = flag_r | sr[32];
        state_nxt = S_Y0;
      end
      S_Y0: begin
        acc_nxt   = 64'(prod);
        state_nxt = S_Y1;
      end
      S_Y1: begin
        acc_nxt   = acc_r + (64'(prod) << 16);
        state_nxt = S_YF;
      end
      S_YF: begin
        ry_nxt    = sr[31:0];
        flag_nxt  = flag_r | sr[32];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_raw_nxt   = raw_r;
          out_x_nxt     = rx_r;
          out_y_nxt     = ry_r;
          out_z_nxt     = rz_r;
          out_sat_nxt   = flag_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      clr_col_r   <= '0;
      clr_row_r   <= '0;
      ifx_r       <= dtpc_pkg::RST_INV_FX;
      ify_r       <= dtpc_pkg::RST_INV_FY;
      cx_r        <= dtpc_pkg::RST_CX;
      cy_r        <= dtpc_pkg::RST_CY;
      base_r      <= dtpc_pkg::RST_BASE;
      off_r       <= dtpc_pkg::RST_OFFSET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_col_r   <= clr_col_nxt;
      clr_row_r   <= clr_row_nxt;
      ifx_r       <= ifx_nxt;
      ify_r       <= ify_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      base_r      <= base_nxt;
      off_r       <= off_nxt;
      out_valid_r <= out_valid_nxt;
    end
    px_r <= px_nxt; py_r <= py_nxt; idx_r <= idx_nxt; raw_r <= raw_nxt;
    den_neg_r <= den_neg_nxt; den_zero_r <= den_zero_nxt; mag_r <= mag_nxt;
    ux_r <= ux_nxt; uy_r <= uy_nxt;
    div_n_r <= div_n_nxt; div_d_r <= div_d_nxt; rem_r <= rem_nxt;
    quo_r <= quo_nxt; cnt_r <= cnt_nxt;
    zmag_r <= zmag_nxt; z_neg_r <= z_neg_nxt; acc_r <= acc_nxt;
    rx_r <= rx_nxt; ry_r <= ry_nxt; rz_r <= rz_nxt; flag_r <= flag_nxt;
    out_raw_r <= out_raw_nxt; out_x_r <= out_x_nxt; out_y_r <= out_y_nxt;
    out_z_r <= out_z_nxt; out_sat_r <= out_sat_nxt;
  end

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_raw_depth = out_raw_r;
  assign out_cloud_x   = out_x_r;
  assign out_cloud_y   = out_y_r;
  assign out_cloud_z   = out_z_r;
  assign out_saturated = out_sat_r;

endmodule

`default_nettype wire

// ===== hw/rtl/dtpc_checker.sv =====
// ============================================================================
// dtpc_checker
// Port-level checks for the depth-to-point-cloud converter.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dtpc_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic [1:0]                   in_action,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic signed [31:0]           out_cloud_x,
  input wire logic signed [31:0]           out_cloud_z,
  input wire logic                         cfg_ready
);

  // The clearing pass holds the input off straight after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during the clearing pass");

  // A pixel request keeps the block busy on the following cycle.
  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action == dtpc_pkg::ACT_PIXEL) |=> in_stall)
    else $error("block ready straight after a pixel request");

  // z is clamped to at most full positive scale, so -z never reaches full negative scale.
  a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cloud_z != dtpc_pkg::S32_MIN))
    else $error("-z at full negative scale");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cloud_x))
    else $error("stalled result word changed");

endmodule

bind depth_to_point_cloud dtpc_checker u_dtpc_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_depth_to_point_cloud.sv =====
// ----------------------------------------------------------------------------
// tb_depth_to_point_cloud
// Self-checking testbench for the depth-to-point-cloud converter. A local
// model of the depth frame, remap table and pinhole arithmetic predicts each
// pixel result, which is compared field by field with the block's output
// under directed cases, configuration sweeps and random traffic with stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_depth_to_point_cloud;

  typedef struct {
    logic [10:0] raw;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        sat;
  } point_t;

  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;
  localparam int     CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = '0;
  logic [9:0] in_pixel_x = '0;
  logic [8:0] in_pixel_y = '0;
  logic [10:0] in_depth_value = '0;
  logic [9:0] in_map_x = '0;
  logic [8:0] in_map_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [10:0] out_raw_depth;
  logic signed [31:0] out_cloud_x, out_cloud_y, out_cloud_z;
  logic out_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [dtpc_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [dtpc_pkg::CDATA_W-1:0] cfg_data = '0;

  depth_to_point_cloud DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Local copy of the block's state.
  logic [10:0] depth_mem [0:dtpc_pkg::PIX_COUNT-1];
  bit          depth_known [0:dtpc_pkg::PIX_COUNT-1];
  logic [9:0]  map_col [0:dtpc_pkg::PIX_COUNT-1];
  logic [8:0]  map_row [0:dtpc_pkg::PIX_COUNT-1];
  logic [23:0] m_ifx, m_ify;
  logic [13:0] m_cx;
  logic [12:0] m_cy;
  logic [19:0] m_base;
  logic [20:0] m_off;

  point_t expected_points[$];
  int     error_count = 0;
  int     cycle_count = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;

  initial begin
    for (int i = 0; i < dtpc_pkg::PIX_COUNT; i++) begin
      map_col[i] = 10'(i % dtpc_pkg::FRAME_WIDTH);
      map_row[i] = 9'(i / dtpc_pkg::FRAME_WIDTH);
      depth_known[i] = 1'b0;
    end
    m_ifx = dtpc_pkg::RST_INV_FX; m_ify = dtpc_pkg::RST_INV_FY;
    m_cx = dtpc_pkg::RST_CX; m_cy = dtpc_pkg::RST_CY;
    m_base = dtpc_pkg::RST_BASE; m_off = dtpc_pkg::RST_OFFSET;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  function automatic longint round_mag(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clip32(longint v, inout logic flag);
    if (v > MAX32) begin flag = 1'b1; return MAX32; end
    if (v < MIN32) begin flag = 1'b1; return MIN32; end
    return v;
  endfunction

  function automatic int clamp_col(logic [9:0] c);
    return (c > dtpc_pkg::FRAME_WIDTH - 1) ? dtpc_pkg::FRAME_WIDTH - 1 : int'(c);
  endfunction

  function automatic int clamp_row(logic [8:0] r);
    return (r > dtpc_pkg::FRAME_HEIGHT - 1) ? dtpc_pkg::FRAME_HEIGHT - 1 : int'(r);
  endfunction

  // Back-projects one pixel and queues the point the block should return.
  task automatic project_pixel(int px, int py);
    int     idx, src;
    longint d, off, den, num, mag, q, z, u, v;
    point_t p;
    logic   flag;
    idx = py * dtpc_pkg::FRAME_WIDTH + px;
    src = int'(map_row[idx]) * dtpc_pkg::FRAME_WIDTH + int'(map_col[idx]);
    d = longint'(depth_mem[src]);
    flag = 1'b0;
    off = longint'($signed(m_off));
    den = off - (d << 20);
    if (den == 0) begin
      z = MAX32;
      flag = 1'b1;
    end else begin
      num = (longint'(dtpc_pkg::Z_SCALE) * longint'(m_base)) << 16;
      mag = (den < 0) ? -den : den;
      q = (2 * num + mag) / (2 * mag);
      if (q > (longint'(1) << 31)) begin q = longint'(1) << 31; flag = 1'b1; end
      z = (den < 0) ? -q : q;
      if (z > MAX32) begin z = MAX32; flag = 1'b1; end
    end
    u = round_mag((longint'(px) * 16 - longint'(m_cx)) * longint'(m_ifx), 8);
    v = round_mag((longint'(py) * 16 - longint'(m_cy)) * longint'(m_ify), 8);
    p.x = 32'(clip32(round_mag(u * z, 20), flag));
    p.y = 32'(clip32(-round_mag(v * z, 20), flag));
    p.z = 32'(clip32(-z, flag));
    p.raw = depth_mem[idx];
    p.sat = flag;
    expected_points.push_back(p);
  endtask

  task automatic apply_word(logic [1:0] act, logic [9:0] pxr, logic [8:0] pyr,
                            logic [10:0] dv, logic [9:0] mx, logic [8:0] my);
    int px, py, idx;
    px = clamp_col(pxr);
    py = clamp_row(pyr);
    idx = py * dtpc_pkg::FRAME_WIDTH + px;
    case (act)
      dtpc_pkg::ACT_DEPTH: begin
        depth_mem[idx] = dv & dtpc_pkg::DEPTH_MASK;
        depth_known[idx] = 1'b1;
      end
      dtpc_pkg::ACT_REMAP: begin
        map_col[idx] = 10'(clamp_col(mx));
        map_row[idx] = 9'(clamp_row(my));
      end
      dtpc_pkg::ACT_PIXEL: project_pixel(px, py);
      default: ;
    endcase
  endtask

  task automatic send_word(logic [1:0] act, logic [9:0] px, logic [8:0] py,
                           logic [10:0] dv, logic [9:0] mx, logic [8:0] my);
    in_valid <= 1'b1;
    in_action <= act;
    in_pixel_x <= px;
    in_pixel_y <= py;
    in_depth_value <= dv;
    in_map_x <= mx;
    in_map_y <= my;
    do @(posedge clk); while (in_stall);
    apply_word(act, px, py, dv, mx, my);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic send_depth(logic [9:0] px, logic [8:0] py, logic [10:0] dv);
    send_word(dtpc_pkg::ACT_DEPTH, px, py, dv, 10'($urandom), 9'($urandom));
  endtask

  task automatic send_remap(logic [9:0] px, logic [8:0] py, logic [9:0] mx, logic [8:0] my);
    send_word(dtpc_pkg::ACT_REMAP, px, py, 11'($urandom), mx, my);
  endtask

  // A pixel request is only issued once both depth entries it reads hold data.
  task automatic send_pixel(logic [9:0] pxr, logic [8:0] pyr);
    int idx, src;
    idx = clamp_row(pyr) * dtpc_pkg::FRAME_WIDTH + clamp_col(pxr);
    if (!depth_known[idx]) send_depth(pxr, pyr, 11'($urandom));
    src = int'(map_row[idx]) * dtpc_pkg::FRAME_WIDTH + int'(map_col[idx]);
    if (!depth_known[src])
      send_depth(10'(src % dtpc_pkg::FRAME_WIDTH), 9'(src / dtpc_pkg::FRAME_WIDTH),
                 11'($urandom));
    send_word(dtpc_pkg::ACT_PIXEL, pxr, pyr, 11'($urandom), 10'($urandom),
              9'($urandom));
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [dtpc_pkg::CIDX_W-1:0] index, logic [23:0] value);
    wait_results();
    repeat (80) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      dtpc_pkg::CFG_INV_FX: m_ifx = value;
      dtpc_pkg::CFG_INV_FY: m_ify = value;
      dtpc_pkg::CFG_CX:     m_cx = value[13:0];
      dtpc_pkg::CFG_CY:     m_cy = value[12:0];
      dtpc_pkg::CFG_BASE:   m_base = value[19:0];
      dtpc_pkg::CFG_OFFSET: m_off = value[20:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [23:0] fx, logic [23:0] fy, logic [13:0] cx,
                           logic [12:0] cy, logic [19:0] base, logic [20:0] off);
    write_reg(dtpc_pkg::CFG_INV_FX, fx);
    write_reg(dtpc_pkg::CFG_INV_FY, fy);
    write_reg(dtpc_pkg::CFG_CX, 24'(cx));
    write_reg(dtpc_pkg::CFG_CY, 24'(cy));
    write_reg(dtpc_pkg::CFG_BASE, 24'(base));
    write_reg(dtpc_pkg::CFG_OFFSET, 24'(off));
  endtask

  task automatic write_reset_values();
    write_all(dtpc_pkg::RST_INV_FX, dtpc_pkg::RST_INV_FY, dtpc_pkg::RST_CX,
              dtpc_pkg::RST_CY, dtpc_pkg::RST_BASE, dtpc_pkg::RST_OFFSET);
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s: got %0h, expected %0h", field, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    point_t p;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected word", out_cloud_z, 0);
      end else begin
        p = expected_points.pop_front();
        if (out_raw_depth !== p.raw) report_mismatch("raw_depth", out_raw_depth, p.raw);
        if (out_cloud_x !== p.x) report_mismatch("cloud_x", out_cloud_x, p.x);
        if (out_cloud_y !== p.y) report_mismatch("cloud_y", out_cloud_y, p.y);
        if (out_cloud_z !== p.z) report_mismatch("cloud_z", out_cloud_z, p.z);
        if (out_saturated !== p.sat) report_mismatch("saturated", out_saturated, p.sat);
      end
    end
  end

  function automatic logic [9:0] pick_col();
    case ($urandom_range(3))
      0: return 10'($urandom_range(15));
      1: return 10'($urandom_range(1023, 620));
      2: return 10'($urandom_range(1023));
      default: return 10'($urandom_range(639));
    endcase
  endfunction

  function automatic logic [8:0] pick_row();
    case ($urandom_range(3))
      0: return 9'($urandom_range(15));
      1: return 9'($urandom_range(511, 465));
      2: return 9'($urandom_range(511));
      default: return 9'($urandom_range(479));
    endcase
  endfunction

  task automatic test_directed();
    send_depth(10'd0, 9'd0, 11'd0);
    send_depth(10'd1023, 9'd511, 11'd2047);
    send_depth(10'd5, 9'd3, 11'd1);
    send_pixel(10'd0, 9'd0);
    send_pixel(10'd639, 9'd479);
    send_pixel(10'd1023, 9'd511);
    send_pixel(10'd5, 9'd3);
    // Remap with coordinates past the frame edge, then read through it.
    send_remap(10'd5, 9'd3, 10'd1023, 9'd511);
    send_pixel(10'd5, 9'd3);
    send_remap(10'd639, 9'd479, 10'd0, 9'd0);
    send_pixel(10'd639, 9'd479);
    // The unused action must leave the state untouched.
    send_word(dtpc_pkg::ACT_UNUSED, 10'd0, 9'd0, 11'd2047, 10'd700, 9'd500);
    send_pixel(10'd0, 9'd0);
    send_pixel(10'd639, 9'd479);
  endtask

  task automatic test_config_extremes();
    // A zero offset against a zero sample divides by zero.
    write_all(24'hFFFFFF, 24'hFFFFFF, 14'd0, 13'd0, 20'hFFFFF, 21'd0);
    send_pixel(10'd0, 9'd0);
    send_pixel(10'd639, 9'd479);
    write_all(24'hFFFFFF, 24'hFFFFFF, 14'd10239, 13'd7679, 20'hFFFFF, 21'd1048575);
    send_pixel(10'd0, 9'd0);
    send_pixel(10'd5, 9'd3);
    send_pixel(10'd1023, 9'd511);
    write_all(24'd0, 24'd0, 14'd0, 13'd0, 20'd0, 21'h100000);
    send_pixel(10'd0, 9'd0);
    send_pixel(10'd639, 9'd479);
    write_reset_values();
  endtask

  task automatic test_random_phase(int items, int idle, int stall);
    int kind;
    idle_pct = idle;
    stall_pct = stall;
    for (int n = 0; n < items; n++) begin
      kind = $urandom_range(99);
      if (n == items / 2) wait_results();
      if (kind < 30) send_depth(pick_col(), pick_row(), 11'($urandom));
      else if (kind < 48) send_remap(pick_col(), pick_row(), pick_col(), pick_row());
      else if (kind < 95) send_pixel(pick_col(), pick_row());
      else send_word(dtpc_pkg::ACT_UNUSED, pick_col(), pick_row(), 11'($urandom),
                     10'($urandom), 9'($urandom));
    end
  endtask

  task automatic random_config();
    write_all(24'($urandom_range(60000)), 24'($urandom_range(60000)),
              14'($urandom_range(10239)), 13'($urandom_range(7679)),
              20'($urandom), 21'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random_phase(175, 0, 0);
    random_config();
    test_random_phase(175, 83, 0);
    random_config();
    test_random_phase(175, 0, 83);
    write_reset_values();
    test_random_phase(175, 24, 24);
    wait_results();
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_points.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
